### hw/rtl/mtep_pkg.sv
// Shared types, codes and constants for the MIDI track event parser.
package mtep_pkg;

    typedef enum logic [3:0] {
        PH_TAG    = 4'd0,
        PH_LEN    = 4'd1,
        PH_DELTA  = 4'd2,
        PH_STATUS = 4'd3,
        PH_DATA   = 4'd4,
        PH_SYSEX  = 4'd5,
        PH_MTYPE  = 4'd6,
        PH_MLEN   = 4'd7,
        PH_BODY   = 4'd8
    } t_phase;

    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_SYSEX   = 3'd1;
    localparam logic [2:0] KIND_COMMON  = 3'd2;
    localparam logic [2:0] KIND_META    = 3'd3;
    localparam logic [2:0] KIND_EOT     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_META        = 8'hFF;
    localparam logic [7:0] META_EOT       = 8'h2F;

    localparam logic [2:0] TAG_LEN       = 3'd4;
    localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;
    localparam logic [27:0] CHUNK_LEN_BYTES = 28'd4;

    typedef struct packed {
        logic        valid;
        logic [2:0]  event_kind;
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  meta_kind;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [27:0] body_length;
    } t_result;

    // "MTrk"
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4D;
            2'd1:    v = 8'h54;
            2'd2:    v = 8'h72;
            default: v = 8'h6B;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/mtep_in_skid.sv
// Input register with skid slot, so the upstream stall is registered.
module mtep_in_skid
    import mtep_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_stall,
    input  logic       i_pop,
    output logic       o_head_valid,
    output logic [7:0] o_head_byte
);

    logic       r_main_valid, r_skid_valid;
    logic [7:0] r_main_byte, r_skid_byte;
    logic       w_accept;

    assign w_accept     = i_valid && !r_skid_valid;
    assign o_stall      = r_skid_valid;
    assign o_head_valid = r_main_valid;
    assign o_head_byte  = r_main_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_accept;
            end
        end else if (w_accept) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_main_byte <= r_skid_valid ? r_skid_byte : i_byte;
        end else if (w_accept) begin
            if (r_main_valid) begin
                r_skid_byte <= i_byte;
            end else begin
                r_main_byte <= i_byte;
            end
        end
    end

endmodule

### hw/rtl/mtep_core.sv
// Parser state and the per-byte step that decodes track events.
module mtep_core
    import mtep_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_tag_prog, n_tag_prog;
    logic [27:0] r_count, n_count;
    logic [27:0] r_delta, n_delta;
    logic [2:0]  r_qbs, n_qbs;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_mtype, n_mtype;
    logic [7:0]  r_data0, n_data0;
    logic [7:0]  r_data1, n_data1;
    logic [27:0] r_len, n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_tag_prog <= '0;
            r_count    <= '0;
            r_delta    <= '0;
            r_qbs      <= '0;
            r_status   <= '0;
            r_mtype    <= '0;
            r_data0    <= '0;
            r_data1    <= '0;
            r_len      <= '0;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_tag_prog <= n_tag_prog;
            r_count    <= n_count;
            r_delta    <= n_delta;
            r_qbs      <= n_qbs;
            r_status   <= n_status;
            r_mtype    <= n_mtype;
            r_data0    <= n_data0;
            r_data1    <= n_data1;
            r_len      <= n_len;
        end
    end

    always_comb begin
        logic [27:0] dec_count;
        logic [2:0]  qbs_inc;
        logic [2:0]  prog_next;
        logic [27:0] len_next;

        n_phase    = r_phase;
        n_tag_prog = r_tag_prog;
        n_count    = r_count;
        n_delta    = r_delta;
        n_qbs      = r_qbs;
        n_status   = r_status;
        n_mtype    = r_mtype;
        n_data0    = r_data0;
        n_data1    = r_data1;
        n_len      = r_len;
        o_result   = '0;

        dec_count = (r_count != '0) ? r_count - 28'd1 : '0;
        qbs_inc   = r_qbs + 3'd1;
        len_next  = {r_len[20:0], i_byte[6:0]};
        prog_next = '0;

        case (r_phase)
            PH_LEN: begin
                n_count = dec_count;
                if (dec_count == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            PH_DELTA: begin
                n_delta = {r_delta[20:0], i_byte[6:0]};
                n_qbs   = qbs_inc;
                if (i_byte[7]) begin
                    if (qbs_inc >= VLQ_MAX_BYTES) begin
                        o_result.valid       = 1'b1;
                        o_result.event_kind  = KIND_ERROR;
                        o_result.status_byte = i_byte;
                    end
                end else begin
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                n_status = i_byte;
                n_qbs    = '0;
                if (!i_byte[7]) begin
                    o_result.valid       = 1'b1;
                    o_result.event_kind  = KIND_ERROR;
                    o_result.status_byte = i_byte;
                end else if (i_byte < ST_SYSEX_START) begin
                    // program change and channel pressure carry one data byte
                    n_count = (i_byte[7:5] == 3'b110) ? 28'd1 : 28'd2;
                    n_phase = PH_DATA;
                end else begin
                    case (i_byte) inside
                        ST_SYSEX_START: n_phase = PH_SYSEX;
                        ST_MTC_QFRAME, ST_SONG_SEL: begin
                            n_count = 28'd1;
                            n_phase = PH_DATA;
                        end
                        ST_SONG_POS: begin
                            n_count = 28'd2;
                            n_phase = PH_DATA;
                        end
                        ST_SYSEX_END: begin
                            o_result.valid       = 1'b1;
                            o_result.event_kind  = KIND_SYSEX;
                            o_result.status_byte = i_byte;
                        end
                        ST_META: n_phase = PH_MTYPE;
                        default: begin
                            o_result.valid       = 1'b1;
                            o_result.event_kind  = KIND_COMMON;
                            o_result.status_byte = i_byte;
                        end
                    endcase
                end
            end
            PH_DATA: begin
                if (r_qbs[0]) begin
                    n_data1 = i_byte;
                end else begin
                    n_data0 = i_byte;
                end
                n_qbs   = qbs_inc;
                n_count = dec_count;
                if (dec_count == '0) begin
                    o_result.valid       = 1'b1;
                    o_result.event_kind  = (r_status < ST_SYSEX_START) ? KIND_CHANNEL
                                                                        : KIND_COMMON;
                    o_result.status_byte = r_status;
                    o_result.first_data  = n_data0;
                    o_result.second_data = n_data1;
                end
            end
            PH_SYSEX: begin
                if (i_byte == ST_SYSEX_END) begin
                    o_result.valid       = 1'b1;
                    o_result.event_kind  = KIND_SYSEX;
                    o_result.status_byte = ST_SYSEX_START;
                end
            end
            PH_MTYPE: begin
                n_mtype = i_byte;
                n_len   = '0;
                n_qbs   = '0;
                n_phase = PH_MLEN;
            end
            PH_MLEN: begin
                n_len = len_next;
                n_qbs = qbs_inc;
                if (i_byte[7]) begin
                    if (qbs_inc >= VLQ_MAX_BYTES) begin
                        o_result.valid       = 1'b1;
                        o_result.event_kind  = KIND_ERROR;
                        o_result.status_byte = i_byte;
                    end
                end else if (len_next == '0) begin
                    o_result.valid       = 1'b1;
                    o_result.event_kind  = (r_mtype == META_EOT) ? KIND_EOT : KIND_META;
                    o_result.status_byte = ST_META;
                    o_result.meta_kind   = r_mtype;
                end else begin
                    n_count = len_next;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_count = dec_count;
                if (dec_count == '0) begin
                    o_result.valid       = 1'b1;
                    o_result.event_kind  = (r_mtype == META_EOT) ? KIND_EOT : KIND_META;
                    o_result.status_byte = ST_META;
                    o_result.meta_kind   = r_mtype;
                    o_result.body_length = r_len;
                end
            end
            default: begin
                // tag hunt; a stray 'M' restarts the match at its first byte
                if (i_byte == tag_byte(r_tag_prog[1:0])) begin
                    prog_next = {1'b0, r_tag_prog[1:0]} + 3'd1;
                end else begin
                    prog_next = (i_byte == tag_byte(2'd0)) ? 3'd1 : 3'd0;
                end
                if (prog_next >= TAG_LEN) begin
                    n_tag_prog = '0;
                    n_phase    = PH_LEN;
                    n_count    = CHUNK_LEN_BYTES;
                end else begin
                    n_tag_prog = prog_next;
                    n_phase    = PH_TAG;
                end
            end
        endcase

        o_result.delta_ticks = o_result.valid ? n_delta : '0;

        // after an event, start the next one; end of track and errors resync
        if (o_result.valid) begin
            n_phase = PH_DELTA;
            n_delta = '0;
            n_qbs   = '0;
            n_data0 = '0;
            n_data1 = '0;
            n_len   = '0;
            n_count = '0;
            if (o_result.event_kind == KIND_EOT || o_result.event_kind == KIND_ERROR) begin
                n_phase    = PH_TAG;
                n_tag_prog = '0;
            end
        end
    end

endmodule

### hw/rtl/mtep_out_reg.sv
// Result register facing the downstream valid/stall channel.
module mtep_out_reg
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    input  logic        i_stall,
    output logic        o_ready,
    output logic        o_valid,
    output logic [2:0]  o_event_kind,
    output logic [27:0] o_delta_ticks,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_meta_kind,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [27:0] o_body_length
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_res <= i_result;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_kind  = r_res.event_kind;
    assign o_delta_ticks = r_res.delta_ticks;
    assign o_status_byte = r_res.status_byte;
    assign o_meta_kind   = r_res.meta_kind;
    assign o_first_data  = r_res.first_data;
    assign o_second_data = r_res.second_data;
    assign o_body_length = r_res.body_length;

endmodule

### hw/rtl/midi_track_event_parser.sv
// Accepted bytes pass the input register and the parser step into the result register.
// Throughput: one stream byte per cycle unless the full result register is stalled.
// The input skid slot keeps o_stall registered; the result register takes a new
// event in the cycle the previous one is taken.
// Reset: synchronous, active low; parser returns to the tag hunt with all state cleared.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [27:0] o_delta_ticks,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_meta_kind,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [27:0] o_body_length
);

    logic       w_head_valid;
    logic [7:0] w_head_byte;
    logic       w_out_ready;
    logic       w_go;
    t_result    w_result;

    assign w_go = w_head_valid && w_out_ready;

    mtep_in_skid u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte       (i_stream_byte),
        .o_stall      (o_stall),
        .i_pop        (w_go),
        .o_head_valid (w_head_valid),
        .o_head_byte  (w_head_byte)
    );

    mtep_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_byte   (w_head_byte),
        .o_result (w_result)
    );

    mtep_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_go),
        .i_result      (w_result),
        .i_stall       (i_stall),
        .o_ready       (w_out_ready),
        .o_valid       (o_valid),
        .o_event_kind  (o_event_kind),
        .o_delta_ticks (o_delta_ticks),
        .o_status_byte (o_status_byte),
        .o_meta_kind   (o_meta_kind),
        .o_first_data  (o_first_data),
        .o_second_data (o_second_data),
        .o_body_length (o_body_length)
    );

endmodule

### hw/rtl/mtep_checker.sv
// Port-level checks on the parser outputs, bound to the top level.
module mtep_checker
    import mtep_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_event_kind,
    input logic [27:0] o_delta_ticks,
    input logic [7:0]  o_status_byte,
    input logic [7:0]  o_meta_kind,
    input logic [7:0]  o_first_data,
    input logic [7:0]  o_second_data,
    input logic [27:0] o_body_length
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_event_kind) && $stable(o_delta_ticks)
                               && $stable(o_status_byte) && $stable(o_body_length))
        else $error("stalled result item changed");

    a_meta_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == KIND_META || o_event_kind == KIND_EOT)
            |-> o_status_byte == ST_META)
        else $error("meta event without meta status");

    a_non_meta_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != KIND_META && o_event_kind != KIND_EOT
            |-> o_meta_kind == 8'h00 && o_body_length == 28'd0)
        else $error("meta fields set on a non-meta event");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == KIND_ERROR
            |-> o_first_data == 8'h00 && o_second_data == 8'h00)
        else $error("error event carries data bytes");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the MIDI track event parser: bytes in, predicted events checked.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mtep_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [31:0] MTRK_TAG       = 32'h4D54726B;

    typedef logic [7:0] t_byte_q [$];

    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta;
        logic [7:0]  status;
        logic [7:0]  meta;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [27:0] body;
    } t_midi_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [27:0] o_delta_ticks;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_meta_kind;
    logic [7:0]  o_first_data;
    logic [7:0]  o_second_data;
    logic [27:0] o_body_length;

    midi_track_event_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stream_byte (i_stream_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_delta_ticks (o_delta_ticks),
        .o_status_byte (o_status_byte),
        .o_meta_kind   (o_meta_kind),
        .o_first_data  (o_first_data),
        .o_second_data (o_second_data),
        .o_body_length (o_body_length)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser state mirrored by the predictor
    t_phase      trk_phase = PH_TAG;
    logic [2:0]  trk_tag_pos = '0;
    logic [27:0] trk_countdown = '0;
    logic [27:0] trk_delta = '0;
    logic [2:0]  trk_qcount = '0;
    logic [7:0]  trk_status = '0;
    logic [7:0]  trk_meta_type = '0;
    logic [7:0]  trk_data [2] = '{8'h00, 8'h00};
    logic [27:0] trk_length = '0;

    t_midi_event expected_events [$];

    int unsigned mismatches = 0;
    int unsigned events_checked = 0;
    int unsigned kinds_seen [6] = '{0, 0, 0, 0, 0, 0};
    int unsigned bytes_sent = 0;
    int unsigned noise_bytes = 0;
    int unsigned quiet_cycles = 0;

    bit          calm = 1'b0;
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_left = 0;
    int unsigned rx_wait;

    function automatic void start_next_event();
        trk_phase = PH_DELTA;
        trk_delta = '0;
        trk_qcount = '0;
        trk_data[0] = '0;
        trk_data[1] = '0;
        trk_length = '0;
        trk_countdown = '0;
    endfunction

    function automatic void resume_tag_hunt();
        start_next_event();
        trk_phase = PH_TAG;
        trk_tag_pos = '0;
    endfunction

    function automatic void post_event(input logic [2:0] kind, input logic [7:0] status,
                                       input logic [7:0] meta, input logic [7:0] d0,
                                       input logic [7:0] d1, input logic [27:0] body);
        t_midi_event ev;
        ev.kind = kind;
        ev.delta = trk_delta;
        ev.status = status;
        ev.meta = meta;
        ev.d0 = d0;
        ev.d1 = d1;
        ev.body = body;
        expected_events.push_back(ev);
        if (kind == KIND_EOT || kind == KIND_ERROR) begin
            resume_tag_hunt();
        end else begin
            start_next_event();
        end
    endfunction

    function automatic void close_meta();
        post_event((trk_meta_type == META_EOT) ? KIND_EOT : KIND_META, ST_META, trk_meta_type,
                   8'h00, 8'h00, trk_length);
    endfunction

    function automatic void decode_stream_byte(input logic [7:0] b);
        case (trk_phase)
            PH_LEN: begin
                if (trk_countdown != 0) trk_countdown = trk_countdown - 28'd1;
                if (trk_countdown == 0) start_next_event();
            end
            PH_DELTA: begin
                trk_delta = {trk_delta[20:0], b[6:0]};
                trk_qcount = trk_qcount + 3'd1;
                if (b[7]) begin
                    if (trk_qcount >= VLQ_MAX_BYTES) post_event(KIND_ERROR, b, '0, '0, '0, '0);
                end else begin
                    trk_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                trk_status = b;
                if (!b[7]) begin
                    post_event(KIND_ERROR, b, '0, '0, '0, '0);
                end else begin
                    trk_qcount = '0;
                    if (b < ST_SYSEX_START) begin
                        // program change and channel pressure carry one data byte
                        trk_countdown = (b[7:5] == 3'b110) ? 28'd1 : 28'd2;
                        trk_phase = PH_DATA;
                    end else begin
                        case (b)
                            ST_SYSEX_START: trk_phase = PH_SYSEX;
                            ST_MTC_QFRAME, ST_SONG_SEL: begin
                                trk_countdown = 28'd1;
                                trk_phase = PH_DATA;
                            end
                            ST_SONG_POS: begin
                                trk_countdown = 28'd2;
                                trk_phase = PH_DATA;
                            end
                            ST_SYSEX_END: post_event(KIND_SYSEX, b, '0, '0, '0, '0);
                            ST_META: trk_phase = PH_MTYPE;
                            default: post_event(KIND_COMMON, b, '0, '0, '0, '0);
                        endcase
                    end
                end
            end
            PH_DATA: begin
                trk_data[trk_qcount[0]] = b;
                trk_qcount = trk_qcount + 3'd1;
                if (trk_countdown != 0) trk_countdown = trk_countdown - 28'd1;
                if (trk_countdown == 0) begin
                    post_event((trk_status < ST_SYSEX_START) ? KIND_CHANNEL : KIND_COMMON,
                               trk_status, '0, trk_data[0], trk_data[1], '0);
                end
            end
            PH_SYSEX: begin
                if (b == ST_SYSEX_END) post_event(KIND_SYSEX, ST_SYSEX_START, '0, '0, '0, '0);
            end
            PH_MTYPE: begin
                trk_meta_type = b;
                trk_length = '0;
                trk_qcount = '0;
                trk_phase = PH_MLEN;
            end
            PH_MLEN: begin
                trk_length = {trk_length[20:0], b[6:0]};
                trk_qcount = trk_qcount + 3'd1;
                if (b[7]) begin
                    if (trk_qcount >= VLQ_MAX_BYTES) post_event(KIND_ERROR, b, '0, '0, '0, '0);
                end else if (trk_length == 0) begin
                    close_meta();
                end else begin
                    trk_countdown = trk_length;
                    trk_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (trk_countdown != 0) trk_countdown = trk_countdown - 28'd1;
                if (trk_countdown == 0) close_meta();
            end
            default: begin
                // a stray 'M' restarts the match at the first tag byte
                if (b == MTRK_TAG[8 * (3 - trk_tag_pos[1:0]) +: 8]) begin
                    trk_tag_pos = {1'b0, trk_tag_pos[1:0]} + 3'd1;
                end else begin
                    trk_tag_pos = (b == MTRK_TAG[31:24]) ? 3'd1 : 3'd0;
                end
                if (trk_tag_pos >= TAG_LEN) begin
                    trk_tag_pos = '0;
                    trk_phase = PH_LEN;
                    trk_countdown = CHUNK_LEN_BYTES;
                end else begin
                    trk_phase = PH_TAG;
                end
            end
        endcase
    endfunction

    function automatic void check_event();
        t_midi_event want;
        if (o_event_kind <= KIND_ERROR) kinds_seen[o_event_kind]++;
        if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("event with nothing expected: kind %0d delta %0d status %02h",
                         o_event_kind, o_delta_ticks, o_status_byte);
            end
            return;
        end
        want = expected_events.pop_front();
        events_checked++;
        if (o_event_kind !== want.kind || o_delta_ticks !== want.delta
                || o_status_byte !== want.status || o_meta_kind !== want.meta
                || o_first_data !== want.d0 || o_second_data !== want.d1
                || o_body_length !== want.body) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch %0d expected: kind %0d delta %0d status %02h meta %02h",
                         mismatches, want.kind, want.delta, want.status, want.meta);
                $display("    data %02h %02h body %0d", want.d0, want.d1, want.body);
                $display("  actual: kind %0d delta %0d status %02h meta %02h",
                         o_event_kind, o_delta_ticks, o_status_byte, o_meta_kind);
                $display("    data %02h %02h body %0d",
                         o_first_data, o_second_data, o_body_length);
            end
        end
    endfunction

    // outputs are checked before the input of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) check_event();
            if (i_valid && !o_stall) decode_stream_byte(i_stream_byte);
        end
    end

    // receiver: random wait per item, plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            rx_wait = calm ? 0 : $urandom_range(0, 9);
            rx_left <= rx_wait;
            i_stall <= (rx_wait != 0);
        end else if (rx_left > 1) begin
            rx_left <= rx_left - 1;
            i_stall <= 1'b1;
        end else begin
            rx_left <= 0;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d events outstanding",
                     quiet_cycles, expected_events.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_burst(input t_byte_q seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic send_vlq(input logic [27:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--) send_byte({i != 0, v[7 * i +: 7]});
    endtask

    task automatic send_header();
        send_burst('{MTRK_TAG[31:24], MTRK_TAG[23:16], MTRK_TAG[15:8], MTRK_TAG[7:0]});
        repeat (4) send_byte(rand_byte());
    endtask

    task automatic send_delta(output bit overlong);
        int unsigned pick;
        int nb;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r = $urandom;
        overlong = 1'b0;
        if (pick < 2) begin
            overlong = 1'b1;
            repeat (4) begin
                r = $urandom;
                send_byte({1'b1, r[6:0]});
            end
        end else begin
            nb = (pick < 55) ? 1 : (pick < 80) ? 2 : (pick < 92) ? 3 : 4;
            send_vlq(r[27:0], nb);
        end
    endtask

    task automatic send_end_of_track();
        int unsigned len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        send_burst('{ST_META, META_EOT, len[7:0]});
        repeat (len) send_byte(rand_byte());
    endtask

    task automatic test_tag_hunt();
        // doubled 'M' before the tag, then channel statuses at their extremes
        send_burst('{8'h4D, 8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h06,
                     8'h00, 8'h80, 8'h00, 8'h7F,
                     8'h7F, 8'hC0, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hDF, 8'h80,
                     8'h00, 8'hEF, 8'hFF, 8'h00});
    endtask

    task automatic test_system_common();
        send_burst('{8'h00, ST_SYSEX_START, 8'h01, ST_SYSEX_END,
                     8'h00, ST_SYSEX_END,
                     8'h00, ST_MTC_QFRAME, 8'h55,
                     8'h00, ST_SONG_POS, 8'h00, 8'h7F,
                     8'h00, ST_SONG_SEL, 8'h7F,
                     8'h00, 8'hF4, 8'h00, 8'hF5, 8'h00, 8'hF6, 8'h00, 8'hF8, 8'h00, 8'hFE});
    endtask

    task automatic test_meta_events();
        // zero length, short body, padded four-byte length, then end of track
        send_burst('{8'h00, ST_META, 8'h00, 8'h00,
                     8'h00, ST_META, 8'hFF, 8'h02, 8'hAA, 8'hBB,
                     8'h00, ST_META, 8'h05, 8'h80, 8'h80, 8'h80, 8'h01, 8'hCC,
                     8'h00, ST_META, META_EOT, 8'h00});
    endtask

    task automatic test_error_paths();
        send_burst('{8'h4D, 8'h54, 8'h00});
        send_header();
        send_burst('{8'h80, 8'h80, 8'h80, 8'h80});
        send_header();
        send_burst('{8'h00, ST_META, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_header();
        send_burst('{8'h81, 8'h00, 8'h7F});
    endtask

    task automatic test_long_meta();
        // end of track with a two-byte length still skips its body
        send_header();
        send_burst('{8'h00, ST_META, META_EOT, 8'h81, 8'h00});
        repeat (128) send_byte(rand_byte());
    endtask

    task automatic test_backpressure();
        logic [7:0] chan;
        calm = 1'b1;
        hold_seq <= hold_seq + 1;
        send_header();
        repeat (60) begin
            chan = rand_byte();
            send_byte(8'h00);
            send_byte({4'h9, chan[3:0]});
            send_byte(rand_byte());
            send_byte(rand_byte());
        end
        send_burst('{8'h00, ST_META, META_EOT, 8'h00});
        calm = 1'b0;
    endtask

    task automatic run_random_track(inout bit dirty);
        int unsigned n_events;
        int unsigned pick;
        int unsigned len;
        int nb;
        logic [7:0] st;
        logic [7:0] r;
        bit ended;
        bit overlong;
        calm = ($urandom_range(0, 3) == 0);
        if (!dirty) begin
            repeat ($urandom_range(0, 4)) begin
                send_byte(rand_byte());
                noise_bytes++;
            end
            if ($urandom_range(0, 4) == 0) begin
                send_burst('{8'h4D, 8'h54, 8'h72});
                noise_bytes += 3;
            end
        end
        dirty = 1'b0;
        send_header();
        n_events = $urandom_range(1, 12);
        ended = 1'b0;
        for (int k = 0; k < n_events && !ended; k++) begin
            send_delta(overlong);
            pick = $urandom_range(0, 99);
            if (overlong) begin
                ended = 1'b1;
            end else if (pick < 40) begin
                pick = $urandom_range(8'h80, 8'hEF);
                st = pick[7:0];
                send_byte(st);
                send_byte(rand_byte());
                if (st[7:5] != 3'b110) send_byte(rand_byte());
            end else if (pick < 48) begin
                send_byte(ST_SYSEX_START);
                repeat ($urandom_range(0, 6)) begin
                    st = rand_byte();
                    if (st == ST_SYSEX_END) st = 8'h00;
                    send_byte(st);
                end
                send_byte(ST_SYSEX_END);
            end else if (pick < 52) begin
                send_byte(ST_SYSEX_END);
            end else if (pick < 64) begin
                pick = $urandom_range(8'hF1, 8'hFE);
                st = pick[7:0];
                if (st == ST_SYSEX_END) st = 8'hF4;
                send_byte(st);
                if (st == ST_MTC_QFRAME || st == ST_SONG_SEL) begin
                    send_byte(rand_byte());
                end else if (st == ST_SONG_POS) begin
                    send_byte(rand_byte());
                    send_byte(rand_byte());
                end
            end else if (pick < 86) begin
                send_byte(ST_META);
                st = rand_byte();
                if (st == META_EOT) st = 8'h01;
                send_byte(st);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 160)
                                                    : $urandom_range(0, 6);
                nb = (len > 127) ? 2 : 1;
                if ($urandom_range(0, 4) == 0) nb = $urandom_range(nb, 4);
                send_vlq(len[27:0], nb);
                repeat (len) send_byte(rand_byte());
            end else if (pick < 90) begin
                r = rand_byte();
                send_byte({1'b0, r[6:0]});
                ended = 1'b1;
            end else if (pick < 93) begin
                send_byte(ST_META);
                send_byte(rand_byte());
                repeat (4) begin
                    r = rand_byte();
                    send_byte({1'b1, r[6:0]});
                end
                ended = 1'b1;
            end else if (pick < 96) begin
                // cut off after one of two data bytes; the next tag lands mid-event
                r = rand_byte();
                send_byte({4'h9, r[3:0]});
                send_byte(rand_byte());
                ended = 1'b1;
                dirty = 1'b1;
            end else begin
                send_end_of_track();
                ended = 1'b1;
            end
        end
        if (!ended) begin
            send_delta(overlong);
            if (!overlong) send_end_of_track();
        end
    endtask

    task automatic test_random_tracks();
        bit dirty;
        int unsigned start;
        dirty = 1'b0;
        start = bytes_sent - noise_bytes;
        while (bytes_sent - noise_bytes - start < RANDOM_ITEMS) run_random_track(dirty);
        calm = 1'b0;
    endtask

    initial begin
        resume_tag_hunt();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_tag_hunt();
        test_system_common();
        test_meta_events();
        test_error_paths();
        test_long_meta();
        test_backpressure();
        test_random_tracks();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d stream bytes (%0d hunt noise), %0d events, %0d mismatches",
                 bytes_sent, noise_bytes, events_checked, mismatches);
        $display("events by kind: channel %0d sysex %0d common %0d meta %0d eot %0d error %0d",
                 kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4],
                 kinds_seen[5]);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
